[src/lkvc_pkg.sv]
// ----------------------------------------------------------------------------
// lkvc_pkg
// Shared constants, types and helpers of the lru key-value cache.
// ----------------------------------------------------------------------------
package lkvc_pkg;

   localparam int MAX_ENTRIES = 16;
   localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
   localparam int KEY_W       = 32;
   localparam int VAL_W       = 32;
   localparam int CAP_W       = 5;

   localparam logic [CAP_W-1:0] CAP_RESET = 5'd16;

   typedef enum logic {
      OPC_GET = 1'b0,
      OPC_PUT = 1'b1
   } opcode_type;

   typedef logic signed [KEY_W-1:0] key_type;
   typedef logic signed [VAL_W-1:0] val_type;

   // one stored entry, handed from a cell to its right neighbour
   typedef struct packed {
      logic    valid;
      key_type key;
      val_type value;
   } entry_type;

   // lookup result rippling from the tail of the row towards the head
   typedef struct packed {
      logic    hit;
      val_type value;
   } hit_chain_type;

   typedef struct packed {
      logic load;
      logic clear;
   } cell_ctl_type;

   // capacity clamped to 1..MAX_ENTRIES
   function automatic logic [CNT_W-1:0] eff_cap(input logic [CAP_W-1:0] cap);
      logic [CNT_W-1:0] c;
      if (cap == '0) begin
         c = CNT_W'(1);
      end else if (int'(cap) > MAX_ENTRIES) begin
         c = CNT_W'(MAX_ENTRIES);
      end else begin
         c = CNT_W'(cap);
      end
      return c;
   endfunction

endpackage

[src/lkvc_if.sv]
// ----------------------------------------------------------------------------
// lkvc channel interfaces
// Valid/ready channels for request items, response items and the
// capacity register write.
// ----------------------------------------------------------------------------
interface lkvc_req_if
   import lkvc_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic       opcode;
   key_type    key;
   val_type    value;

   modport source (output valid, output opcode, output key, output value, input ready);
   modport sink   (input valid, input opcode, input key, input value, output ready);
endinterface

interface lkvc_rsp_if
   import lkvc_pkg::*;
   ();
   logic       valid;
   logic       ready;
   logic       hit;
   val_type    read_value;

   modport source (output valid, output hit, output read_value, input ready);
   modport sink   (input valid, input hit, input read_value, output ready);
endinterface

interface lkvc_csr_if
   import lkvc_pkg::*;
   ();
   logic             valid;
   logic             ready;
   logic [CAP_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

[src/lru_key_value_cache_unit.sv]
// ----------------------------------------------------------------------------
// lru_key_value_cache_unit
// Fully associative key-value cache with least-recently-used replacement.
// ----------------------------------------------------------------------------
// Usage:
//   req_ch carries one access per item: opcode (get or put), key, value.
//   rsp_ch returns one item per access: hit and read_value (value on a get
//   hit, zero otherwise).
//   csr_ch writes the capacity register; 0 acts as 1, anything above the
//   number of cells acts as the number of cells. Lowering it drops the least
//   recent entries at once. Write it only while no access is in flight.
//   Entries sit in a row of cells ordered by recency, head most recent. An
//   access compares every cell with the key in parallel; the hit entry (or a
//   new one on a put) is loaded into the head while the cells in front of it
//   shift one place towards the tail, and the tail entry falls off when full.
//   The response is registered and valid in the cycle after the access is
//   taken; one item per cycle unless a capacity write is pending, bounded
//   by the key compare and hit ripple along the row. A stalled response
//   holds in the output register; the next access is taken as it drains.
//   Reset empties the cache and sets the capacity to the number of cells.
// ----------------------------------------------------------------------------
module lru_key_value_cache_unit
   import lkvc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   lkvc_req_if.sink   req_ch,
   lkvc_rsp_if.source rsp_ch,
   lkvc_csr_if.sink   csr_ch
);

   entry_type        entries [MAX_ENTRIES];
   entry_type        lefts   [MAX_ENTRIES];
   hit_chain_type    hits    [MAX_ENTRIES];
   hit_chain_type    rights  [MAX_ENTRIES];
   cell_ctl_type     ctls    [MAX_ENTRIES];

   logic [CAP_W-1:0] cap_ff, cap_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             rsp_valid_ff, rsp_valid_in;
   logic             rsp_hit_ff, rsp_hit_in;
   val_type          rsp_value_ff, rsp_value_in;

   logic             accept, csr_write, is_put, hit, full;
   logic [CNT_W-1:0] new_cap, cur_cap;

   assign csr_ch.ready = 1'b1;
   assign csr_write    = csr_ch.valid;
   assign req_ch.ready = (!rsp_valid_ff || rsp_ch.ready) && !csr_ch.valid;
   assign accept       = req_ch.valid && req_ch.ready;
   assign is_put       = (opcode_type'(req_ch.opcode) == OPC_PUT);
   assign hit          = hits[0].hit;
   assign new_cap      = eff_cap(csr_ch.data);
   assign cur_cap      = eff_cap(cap_ff);
   assign full         = (count_ff >= cur_cap);

   // head takes the accessed entry
   assign lefts[0].valid = 1'b1;
   assign lefts[0].key   = req_ch.key;
   assign lefts[0].value = (hit && !is_put) ? hits[0].value : req_ch.value;

   assign rights[MAX_ENTRIES-1].hit   = 1'b0;
   assign rights[MAX_ENTRIES-1].value = '0;

   genvar i;
   generate
      for (i = 0; i < MAX_ENTRIES; i++) begin : g_row
         if (i > 0) begin : g_left
            assign lefts[i] = entries[i-1];
         end
         if (i < MAX_ENTRIES - 1) begin : g_right
            assign rights[i] = hits[i+1];
         end

         // hit: cells up to the hit shift; miss put: valid cells shift and
         // the first free one fills unless full
         assign ctls[i].load = accept && (hit ? hits[i].hit :
            (is_put && ((CNT_W'(i) < count_ff) ||
                        ((CNT_W'(i) == count_ff) && !full))));
         assign ctls[i].clear = csr_write && (CNT_W'(i) >= new_cap);

         lkvc_cell u_cell (
            .clock      (clock),
            .reset      (reset),
            .ctl        (ctls[i]),
            .req_key    (req_ch.key),
            .left_entry (lefts[i]),
            .right_hit  (rights[i]),
            .own_entry  (entries[i]),
            .hit_out    (hits[i])
         );
      end
   endgenerate

   always_comb begin
      cap_in   = cap_ff;
      count_in = count_ff;
      if (csr_write) begin
         cap_in = csr_ch.data;
         if (count_ff > new_cap) begin
            count_in = new_cap;
         end
      end else if (accept && !hit && is_put && !full) begin
         count_in = count_ff + CNT_W'(1);
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_hit_in   = rsp_hit_ff;
      rsp_value_in = rsp_value_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (accept) begin
         rsp_valid_in = 1'b1;
         rsp_hit_in   = hit;
         rsp_value_in = (hit && !is_put) ? hits[0].value : '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cap_ff       <= CAP_RESET;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         cap_ff       <= cap_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.hit        = rsp_hit_ff;
   assign rsp_ch.read_value = rsp_value_ff;

endmodule

[src/lkvc_cell.sv]
// ----------------------------------------------------------------------------
// lkvc_cell
// One place in the recency-ordered row: holds an entry, compares it with the
// request key and shifts in its left neighbour's entry when told to.
// ----------------------------------------------------------------------------
module lkvc_cell
   import lkvc_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  cell_ctl_type  ctl,
   input  key_type       req_key,
   input  entry_type     left_entry,
   input  hit_chain_type right_hit,
   output entry_type     own_entry,
   output hit_chain_type hit_out
);

   logic    valid_ff, valid_in;
   key_type key_ff, key_in;
   val_type value_ff, value_in;
   logic    match;

   assign match = valid_ff && (key_ff == req_key);

   // suffix or of matches: tells the row which cells move on a hit
   assign hit_out.hit   = match || right_hit.hit;
   assign hit_out.value = match ? value_ff : right_hit.value;

   assign own_entry.valid = valid_ff;
   assign own_entry.key   = key_ff;
   assign own_entry.value = value_ff;

   always_comb begin
      valid_in = valid_ff;
      key_in   = key_ff;
      value_in = value_ff;
      if (ctl.clear) begin
         valid_in = 1'b0;
      end else if (ctl.load) begin
         valid_in = left_entry.valid;
         key_in   = left_entry.key;
         value_in = left_entry.value;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      value_ff <= value_in;
   end

endmodule

[src/lkvc_checker.sv]
// ----------------------------------------------------------------------------
// lkvc_checker
// Port-level checks of the lru key-value cache, bound to the top level.
// ----------------------------------------------------------------------------
module lkvc_checker
   import lkvc_pkg::*;
(
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_ready,
   input logic    req_opcode,
   input key_type req_key,
   input logic    rsp_valid,
   input logic    rsp_ready,
   input logic    rsp_hit,
   input val_type rsp_read_value
);

   logic req_take;
   assign req_take = req_valid && req_ready;

   // a waiting response item is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response item dropped while stalled");

   // every accepted item gives a response on the next cycle
   a_rsp_follows: assert property (@(posedge clock) disable iff (reset)
      req_take |=> rsp_valid)
      else $error("no response after accepted item");

   // a miss never carries a value
   a_miss_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_read_value == '0)
      else $error("miss response with nonzero value");

   // a get straight after a put of the same key must hit
   a_put_get_hit: assert property (@(posedge clock) disable iff (reset)
      req_take && (opcode_type'(req_opcode) == OPC_PUT) ##1
      req_take && (opcode_type'(req_opcode) == OPC_GET) && (req_key == $past(req_key))
      |=> rsp_hit)
      else $error("get after put of same key missed");

endmodule

bind lru_key_value_cache_unit lkvc_checker u_lkvc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_valid      (req_ch.valid),
   .req_ready      (req_ch.ready),
   .req_opcode     (req_ch.opcode),
   .req_key        (req_ch.key),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_hit        (rsp_ch.hit),
   .rsp_read_value (rsp_ch.read_value)
);
